>>> sv/pae_pkg.sv
// Shared constants and types for the polygon area and extent unit.
package pae_pkg;

    localparam int DEF_MAX_POINTS  = 1024;
    localparam int DEF_COORD_WIDTH = 24;

    // Shoelace sum is kept as a 58-bit signed value; the area is its magnitude.
    localparam int SUM_W  = 58;
    localparam int AREA_W = SUM_W - 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Fewer vertices than this give a zero area.
    localparam int MIN_POLY_VERTS = 3;

    // Control that travels with a vertex out of the front stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic use_a;
        logic lt3;
        logic too_many;
    } t_front_ctl;

endpackage

>>> sv/pae_if.sv
// Vertex and result channel interfaces for the polygon area and extent unit.
interface pae_vertex_if #(
    parameter int COORD_WIDTH = pae_pkg::DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          last_vertex;

    modport source (output valid, x_coord, y_coord, last_vertex, input ready);
    modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface pae_result_if #(
    parameter int COORD_WIDTH = pae_pkg::DEF_COORD_WIDTH,
    parameter int COUNT_WIDTH = $clog2(pae_pkg::DEF_MAX_POINTS + 1)
);
    logic                          valid;
    logic                          ready;
    logic [COORD_WIDTH-1:0]        box_width;
    logic [COORD_WIDTH-1:0]        box_height;
    logic [pae_pkg::AREA_W-1:0]    area_half_units;
    logic                          overflow;
    logic [COUNT_WIDTH-1:0]        vertex_count;

    modport source (output valid, box_width, box_height, area_half_units, overflow,
                    vertex_count, input ready);
    modport sink   (input valid, box_width, box_height, area_half_units, overflow,
                    vertex_count, output ready);
endinterface

>>> sv/pae_front.sv
// Vertex tracking stage: first/previous vertex, extent, count and cross products.
module pae_front #(
    parameter int MAX_POINTS  = pae_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = pae_pkg::DEF_COORD_WIDTH,
    parameter int CNT_W       = $clog2(MAX_POINTS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_step,
    input  logic signed [COORD_WIDTH-1:0]   i_x,
    input  logic signed [COORD_WIDTH-1:0]   i_y,
    input  logic                            i_last,
    output logic signed [2*COORD_WIDTH-1:0] o_pa,
    output logic signed [2*COORD_WIDTH-1:0] o_qa,
    output logic signed [2*COORD_WIDTH-1:0] o_pb,
    output logic signed [2*COORD_WIDTH-1:0] o_qb,
    output pae_pkg::t_front_ctl             o_ctl,
    output logic [CNT_W-1:0]                o_count,
    output logic [COORD_WIDTH-1:0]          o_box_w,
    output logic [COORD_WIDTH-1:0]          o_box_h
);
    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;

    logic signed [CW-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [CNT_W-1:0]     r_count;
    logic                 r_too_many;

    logic signed [CW-1:0] n_first_x, n_first_y, n_prev_x, n_prev_y;
    logic signed [CW-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic [CNT_W-1:0]     n_count;
    logic                 n_too_many;

    logic signed [PW-1:0] r_pa, r_qa, r_pb, r_qb;
    pae_pkg::t_front_ctl  r_ctl;
    logic [CNT_W-1:0]     r_cnt_out;
    logic [CW-1:0]        r_box_w, r_box_h;

    logic w_room, w_first;

    always_comb begin
        w_room  = (r_count < CNT_W'(MAX_POINTS));
        w_first = (r_count == '0);

        n_first_x  = r_first_x;
        n_first_y  = r_first_y;
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_min_x    = r_min_x;
        n_max_x    = r_max_x;
        n_min_y    = r_min_y;
        n_max_y    = r_max_y;
        n_count    = r_count;
        n_too_many = r_too_many;

        if (!w_room) begin
            n_too_many = 1'b1;
        end else if (w_first) begin
            n_first_x = i_x;
            n_first_y = i_y;
            n_prev_x  = i_x;
            n_prev_y  = i_y;
            n_min_x   = i_x;
            n_max_x   = i_x;
            n_min_y   = i_y;
            n_max_y   = i_y;
            n_count   = r_count + CNT_W'(1);
        end else begin
            n_prev_x = i_x;
            n_prev_y = i_y;
            if (i_x < r_min_x) n_min_x = i_x;
            if (i_x > r_max_x) n_max_x = i_x;
            if (i_y < r_min_y) n_min_y = i_y;
            if (i_y > r_max_y) n_max_y = i_y;
            n_count = r_count + CNT_W'(1);
        end
    end

    // Tracking state: clear after the closing vertex, otherwise advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_min_x    <= '0;
            r_max_x    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
            r_count    <= '0;
            r_too_many <= 1'b0;
        end else if (i_adv && i_step) begin
            if (i_last) begin
                r_first_x  <= '0;
                r_first_y  <= '0;
                r_prev_x   <= '0;
                r_prev_y   <= '0;
                r_min_x    <= '0;
                r_max_x    <= '0;
                r_min_y    <= '0;
                r_max_y    <= '0;
                r_count    <= '0;
                r_too_many <= 1'b0;
            end else begin
                r_first_x  <= n_first_x;
                r_first_y  <= n_first_y;
                r_prev_x   <= n_prev_x;
                r_prev_y   <= n_prev_y;
                r_min_x    <= n_min_x;
                r_max_x    <= n_max_x;
                r_min_y    <= n_min_y;
                r_max_y    <= n_max_y;
                r_count    <= n_count;
                r_too_many <= n_too_many;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl.valid    <= i_step;
            r_ctl.last     <= i_last;
            r_ctl.use_a    <= w_room && !w_first;
            r_ctl.lt3      <= (n_count < CNT_W'(pae_pkg::MIN_POLY_VERTS));
            r_ctl.too_many <= n_too_many;
        end
    end

    // Payload: edge into this vertex, and closing edge back to the first vertex.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pa      <= PW'(r_prev_x) * PW'(i_y);
            r_qa      <= PW'(r_prev_y) * PW'(i_x);
            r_pb      <= PW'(n_prev_x) * PW'(n_first_y);
            r_qb      <= PW'(n_prev_y) * PW'(n_first_x);
            r_cnt_out <= n_count;
            r_box_w   <= n_max_x - n_min_x;
            r_box_h   <= n_max_y - n_min_y;
        end
    end

    assign o_pa    = r_pa;
    assign o_qa    = r_qa;
    assign o_pb    = r_pb;
    assign o_qb    = r_qb;
    assign o_ctl   = r_ctl;
    assign o_count = r_cnt_out;
    assign o_box_w = r_box_w;
    assign o_box_h = r_box_h;

endmodule

>>> sv/polygon_area_and_extent_unit.sv
// Streaming shoelace area: one vertex per cycle while no result waits, five register stages to the result.
// The result of a polygon follows the transfer of its marked vertex through the
// input register, products, terms, accumulator and result register.
// Throughput: one vertex per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears all valid bits, tracking state and sum.
// After reset the unit takes vertices at once; no clearing pass is needed.
module polygon_area_and_extent_unit #(
    parameter int MAX_POINTS  = pae_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = pae_pkg::DEF_COORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pae_vertex_if.sink    i_vtx,
    pae_result_if.source  o_res
);
    localparam int CW     = COORD_WIDTH;
    localparam int PW     = 2 * COORD_WIDTH;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = pae_pkg::SUM_W;
    localparam int AREA_W = pae_pkg::AREA_W;
    // Wide enough for any product and for the sum or difference of two clamped values.
    localparam int EW     = ((PW > SUM_W) ? PW : SUM_W) + 1;

    // Clamp to the signed range of the running sum.
    function automatic logic signed [SUM_W-1:0] f_sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        hi = EW'(pae_pkg::SUM_MAX);
        lo = EW'(pae_pkg::SUM_MIN);
        if (v > hi) return pae_pkg::SUM_MAX;
        if (v < lo) return pae_pkg::SUM_MIN;
        return v[SUM_W-1:0];
    endfunction

    // One shoelace term from two products, each clamped before the difference.
    function automatic logic signed [SUM_W-1:0] f_term(input logic signed [PW-1:0] p,
                                                       input logic signed [PW-1:0] q);
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] sq;
        sp = f_sat(EW'(p));
        sq = f_sat(EW'(q));
        return f_sat(EW'(sp) - EW'(sq));
    endfunction

    // Global advance: every stage moves unless a result waits at the output.
    logic w_adv;

    // Input register.
    logic                 r_s0_valid;
    logic signed [CW-1:0] r_s0_x, r_s0_y;
    logic                 r_s0_last;

    // Front stage outputs (products and side data).
    logic signed [PW-1:0] w_pa, w_qa, w_pb, w_qb;
    pae_pkg::t_front_ctl  w_ctl;
    logic [CNT_W-1:0]     w_count;
    logic [CW-1:0]        w_box_w, w_box_h;

    // Term stage.
    logic                    r_s2_valid, r_s2_last, r_s2_lt3, r_s2_too;
    logic [CNT_W-1:0]        r_s2_cnt;
    logic [CW-1:0]           r_s2_bw, r_s2_bh;
    logic signed [SUM_W-1:0] r_s2_ta, r_s2_tb;

    // Accumulator stage.
    logic signed [SUM_W-1:0] r_acc;
    logic signed [SUM_W-1:0] n_acc_a, n_acc_b;
    logic                    r_s3_valid, r_s3_lt3, r_s3_too;
    logic [CNT_W-1:0]        r_s3_cnt;
    logic [CW-1:0]           r_s3_bw, r_s3_bh;
    logic signed [SUM_W-1:0] r_s3_sum;

    // Result register.
    logic                    r_out_valid;
    logic [CW-1:0]           r_out_bw, r_out_bh;
    logic [AREA_W-1:0]       r_out_area;
    logic                    r_out_too;
    logic [CNT_W-1:0]        r_out_cnt;
    logic [AREA_W-1:0]       n_area;
    logic signed [SUM_W-1:0] w_neg;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_vtx.ready = w_adv;

    // Stage 0: capture the vertex on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_x    <= i_vtx.x_coord;
            r_s0_y    <= i_vtx.y_coord;
            r_s0_last <= i_vtx.last_vertex;
        end
    end

    // Stage 1: vertex tracking and the four cross products.
    pae_front #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .CNT_W       (CNT_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_step  (r_s0_valid),
        .i_x     (r_s0_x),
        .i_y     (r_s0_y),
        .i_last  (r_s0_last),
        .o_pa    (w_pa),
        .o_qa    (w_qa),
        .o_pb    (w_pb),
        .o_qb    (w_qb),
        .o_ctl   (w_ctl),
        .o_count (w_count),
        .o_box_w (w_box_w),
        .o_box_h (w_box_h)
    );

    // Stage 2: clamp products into terms; drop terms that do not apply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= w_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_last <= w_ctl.last;
            r_s2_lt3  <= w_ctl.lt3;
            r_s2_too  <= w_ctl.too_many;
            r_s2_cnt  <= w_count;
            r_s2_bw   <= w_box_w;
            r_s2_bh   <= w_box_h;
            r_s2_ta   <= w_ctl.use_a ? f_term(w_pa, w_qa) : '0;
            r_s2_tb   <= w_ctl.last  ? f_term(w_pb, w_qb) : '0;
        end
    end

    // Stage 3: add the edge term, then the closing term, each with saturation.
    assign n_acc_a = f_sat(EW'(r_acc) + EW'(r_s2_ta));
    assign n_acc_b = f_sat(EW'(n_acc_a) + EW'(r_s2_tb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : n_acc_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_sum <= n_acc_b;
            r_s3_lt3 <= r_s2_lt3;
            r_s3_too <= r_s2_too;
            r_s3_cnt <= r_s2_cnt;
            r_s3_bw  <= r_s2_bw;
            r_s3_bh  <= r_s2_bh;
        end
    end

    // Stage 4: magnitude of the sum; the most negative value maps to the largest area.
    assign w_neg = -r_s3_sum;

    always_comb begin
        if (r_s3_lt3) begin
            n_area = '0;
        end else if (r_s3_sum == pae_pkg::SUM_MIN) begin
            n_area = pae_pkg::SUM_MAX[AREA_W-1:0];
        end else if (r_s3_sum[SUM_W-1]) begin
            n_area = w_neg[AREA_W-1:0];
        end else begin
            n_area = r_s3_sum[AREA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_bw   <= r_s3_bw;
            r_out_bh   <= r_s3_bh;
            r_out_area <= n_area;
            r_out_too  <= r_s3_too;
            r_out_cnt  <= r_s3_cnt;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.box_width       = r_out_bw;
    assign o_res.box_height      = r_out_bh;
    assign o_res.area_half_units = r_out_area;
    assign o_res.overflow        = r_out_too;
    assign o_res.vertex_count    = r_out_cnt;

endmodule

>>> sim/polygon_area_checker.sv
// Watches the vertex and result channels, predicts each polygon summary and compares it.
module polygon_area_checker #(
    parameter int MAX_POINTS  = pae_pkg::DEF_MAX_POINTS,
    parameter int COORD_WIDTH = pae_pkg::DEF_COORD_WIDTH,
    parameter int COUNT_WIDTH = $clog2(MAX_POINTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vtx_valid,
    input  logic                          i_vtx_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic                          i_last_vertex,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [COORD_WIDTH-1:0]        i_box_width,
    input  logic [COORD_WIDTH-1:0]        i_box_height,
    input  logic [pae_pkg::AREA_W-1:0]    i_area_half_units,
    input  logic                          i_overflow,
    input  logic [COUNT_WIDTH-1:0]        i_vertex_count,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W  = pae_pkg::SUM_W;
    localparam int AREA_W = pae_pkg::AREA_W;

    typedef struct {
        logic [COORD_WIDTH-1:0] box_width;
        logic [COORD_WIDTH-1:0] box_height;
        logic [AREA_W-1:0]      area_half_units;
        logic                   overflow;
        logic [COUNT_WIDTH-1:0] vertex_count;
    } t_polygon_summary;

    t_polygon_summary summaries_due[$];

    logic signed [COORD_WIDTH-1:0] first_x, first_y, prev_x, prev_y;
    logic signed [COORD_WIDTH-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [SUM_W-1:0]       shoelace_sum;
    logic [COUNT_WIDTH-1:0]        verts_taken;
    logic                          excess_seen;

    function automatic logic signed [SUM_W-1:0] clamp_to_sum(input longint v);
        if (v > longint'(pae_pkg::SUM_MAX))
            return pae_pkg::SUM_MAX;
        if (v < longint'(pae_pkg::SUM_MIN))
            return pae_pkg::SUM_MIN;
        return SUM_W'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] cross_of(input longint ax, ay, bx, by);
        return clamp_to_sum(longint'(clamp_to_sum(ax * by)) - longint'(clamp_to_sum(ay * bx)));
    endfunction

    task automatic clear_polygon();
        first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
        lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
        shoelace_sum = '0;
        verts_taken  = '0;
        excess_seen  = 1'b0;
    endtask

    task automatic absorb_vertex(input logic signed [COORD_WIDTH-1:0] x, y, input logic last);
        t_polygon_summary        s;
        logic signed [SUM_W-1:0] closed;
        longint                  mag;
        if (verts_taken >= COUNT_WIDTH'(MAX_POINTS)) begin
            excess_seen = 1'b1;
        end else if (verts_taken == '0) begin
            first_x = x; prev_x = x; lo_x = x; hi_x = x;
            first_y = y; prev_y = y; lo_y = y; hi_y = y;
            verts_taken = COUNT_WIDTH'(1);
        end else begin
            shoelace_sum = clamp_to_sum(longint'(shoelace_sum) +
                                        longint'(cross_of(longint'(prev_x), longint'(prev_y),
                                                          longint'(x), longint'(y))));
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
            prev_x = x;
            prev_y = y;
            verts_taken++;
        end
        if (!last)
            return;
        // closing edge runs from the last kept vertex back to the first
        closed = clamp_to_sum(longint'(shoelace_sum) +
                              longint'(cross_of(longint'(prev_x), longint'(prev_y),
                                                longint'(first_x), longint'(first_y))));
        mag = longint'(closed);
        if (verts_taken < COUNT_WIDTH'(pae_pkg::MIN_POLY_VERTS))
            s.area_half_units = '0;
        else if (closed == pae_pkg::SUM_MIN)
            s.area_half_units = AREA_W'(pae_pkg::SUM_MAX);
        else
            s.area_half_units = AREA_W'((mag < 0) ? -mag : mag);
        s.box_width    = COORD_WIDTH'(longint'(hi_x) - longint'(lo_x));
        s.box_height   = COORD_WIDTH'(longint'(hi_y) - longint'(lo_y));
        s.overflow     = excess_seen;
        s.vertex_count = verts_taken;
        summaries_due.insert(summaries_due.size(), s);
        clear_polygon();
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        clear_polygon();
    end

    always @(posedge i_clk) begin
        t_polygon_summary want;
        if (!i_rst_n) begin
            clear_polygon();
            summaries_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (summaries_due.size() == 0) begin
                    $error("result with no polygon pending: area %0d", i_area_half_units);
                    o_mismatches++;
                end else begin
                    want = summaries_due.pop_front();
                    report_field("box_width", longint'(want.box_width),
                                 longint'(i_box_width));
                    report_field("box_height", longint'(want.box_height),
                                 longint'(i_box_height));
                    report_field("area_half_units", longint'(want.area_half_units),
                                 longint'(i_area_half_units));
                    report_field("overflow", longint'(want.overflow),
                                 longint'(i_overflow));
                    report_field("vertex_count", longint'(want.vertex_count),
                                 longint'(i_vertex_count));
                end
            end
            if (i_vtx_valid && i_vtx_ready)
                absorb_vertex(i_x_coord, i_y_coord, i_last_vertex);
        end
        o_outstanding = summaries_due.size();
    end

endmodule

>>> sim/tb_polygon_area_and_extent_unit.sv
// Top of the polygon area and extent testbench: clock, reset, vertex stream and verdict.
module tb_polygon_area_and_extent_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = pae_pkg::DEF_COORD_WIDTH;
    localparam int MAX_VERTS = pae_pkg::DEF_MAX_POINTS;
    localparam int COUNT_W   = $clog2(MAX_VERTS + 1);

    localparam logic signed [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_ZERO = '0;
    localparam logic signed [COORD_W-1:0] C_UNIT = COORD_W'(256);
    localparam logic signed [COORD_W-1:0] C_TWO  = COORD_W'(512);

    localparam int RANDOM_VERTS = 830;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;   // results seen before the long receiver hold

    // How the coordinates of one random polygon are drawn.
    typedef enum int {
        COORD_FULL,
        COORD_NEAR_ZERO,
        COORD_CORNERS
    } t_coord_mix;

    logic i_clk;
    logic i_rst_n;

    bit calm_phase;       // no idling on either side while set
    int vertices_sent;
    int results_seen;
    int mismatches;
    int outstanding;

    pae_vertex_if #(.COORD_WIDTH(COORD_W)) vtx_ch ();
    pae_result_if #(.COORD_WIDTH(COORD_W), .COUNT_WIDTH(COUNT_W)) res_ch ();

    polygon_area_and_extent_unit #(
        .MAX_POINTS (MAX_VERTS),
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_ch),
        .o_res  (res_ch)
    );

    polygon_area_checker #(
        .MAX_POINTS (MAX_VERTS),
        .COORD_WIDTH(COORD_W),
        .COUNT_WIDTH(COUNT_W)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vtx_valid      (vtx_ch.valid),
        .i_vtx_ready      (vtx_ch.ready),
        .i_x_coord        (vtx_ch.x_coord),
        .i_y_coord        (vtx_ch.y_coord),
        .i_last_vertex    (vtx_ch.last_vertex),
        .i_res_valid      (res_ch.valid),
        .i_res_ready      (res_ch.ready),
        .i_box_width      (res_ch.box_width),
        .i_box_height     (res_ch.box_height),
        .i_area_half_units(res_ch.area_half_units),
        .i_overflow       (res_ch.overflow),
        .i_vertex_count   (res_ch.vertex_count),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the result stream stalls or never drains.
    initial begin
        #5ms;
        $display("polygon_area_and_extent_unit: mismatch");
        $finish;
    end

    // Count result transfers; the receiver uses this to time its long hold.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            results_seen++;
    end

    // Receiver: drop ready at random, once hold it low long enough for the
    // pipeline to back up into the vertex channel.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                res_ch.ready = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                hold_done    = 1'b1;
            end else begin
                res_ch.ready = calm_phase || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one vertex, idling first at random, and hold it until the transfer.
    // Called and returns at a falling edge.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
        while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
            vtx_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        vtx_ch.valid       = 1'b1;
        vtx_ch.x_coord     = x;
        vtx_ch.y_coord     = y;
        vtx_ch.last_vertex = last;
        do @(posedge i_clk); while (!vtx_ch.ready);
        @(negedge i_clk);
        vertices_sent++;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input t_coord_mix mix);
        case (mix)
            COORD_NEAR_ZERO: return COORD_W'($urandom_range(8191)) - COORD_W'(4096);
            COORD_CORNERS: begin
                case ($urandom_range(3))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:         return COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_polygon(input int verts, input t_coord_mix mix);
        for (int k = 0; k < verts; k++)
            send_vertex(pick_coord(mix), pick_coord(mix), k == verts - 1);
    endtask

    initial begin
        int         verts;
        int         roll;
        t_coord_mix mix;

        i_rst_n            = 1'b0;
        calm_phase         = 1'b0;
        vertices_sent      = 0;
        results_seen       = 0;
        vtx_ch.valid       = 1'b0;
        vtx_ch.x_coord     = '0;
        vtx_ch.y_coord     = '0;
        vtx_ch.last_vertex = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single vertex at opposite extremes: zero extent, zero area.
        send_vertex(C_MIN, C_MAX, 1'b1);
        // Two vertices spanning the full range: widest box, still no area.
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b1);
        // Triangle on the extreme corners.
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        // Unit square counterclockwise, then clockwise (negative sum).
        send_vertex(C_ZERO, C_ZERO, 1'b0);
        send_vertex(C_UNIT, C_ZERO, 1'b0);
        send_vertex(C_UNIT, C_UNIT, 1'b0);
        send_vertex(C_ZERO, C_UNIT, 1'b1);
        send_vertex(C_ZERO, C_UNIT, 1'b0);
        send_vertex(C_UNIT, C_UNIT, 1'b0);
        send_vertex(C_UNIT, C_ZERO, 1'b0);
        send_vertex(C_ZERO, C_ZERO, 1'b1);
        // Collinear points: degenerate, zero area.
        send_vertex(-C_UNIT, -C_UNIT, 1'b0);
        send_vertex(C_ZERO, C_ZERO, 1'b0);
        send_vertex(C_TWO, C_TWO, 1'b1);

        // Random polygons, mostly small; a calm stretch in the middle.
        while (vertices_sent < RANDOM_VERTS) begin
            calm_phase = (vertices_sent >= 300 && vertices_sent < 450);
            roll = $urandom_range(99);
            if (roll < 10)
                verts = $urandom_range(2, 1);
            else if (roll < 80)
                verts = $urandom_range(8, 3);
            else
                verts = $urandom_range(20, 9);
            roll = $urandom_range(99);
            mix = (roll < 55) ? COORD_FULL : (roll < 80) ? COORD_NEAR_ZERO : COORD_CORNERS;
            send_polygon(verts, mix);
        end
        calm_phase = 1'b0;

        // Close with a small polygon near the origin.
        send_polygon(5, COORD_NEAR_ZERO);
        vtx_ch.valid = 1'b0;

        // Drain, then allow for the pipeline depth so stray results surface.
        wait (outstanding == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("polygon_area_and_extent_unit: match");
        else
            $display("polygon_area_and_extent_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
sv/pae_pkg.sv
sv/pae_if.sv
sv/pae_front.sv
sv/polygon_area_and_extent_unit.sv
sim/polygon_area_checker.sv
sim/tb_polygon_area_and_extent_unit.sv
